// ===== hdl/hgs_pkg.sv =====
// Shared constants, types and helper functions for the heat grid store.
package hgs_pkg;

    localparam int MAX_WIDTH      = 64;
    localparam int MAX_HEIGHT     = 64;
    localparam int X_BITS         = $clog2(MAX_WIDTH);
    localparam int Y_BITS         = $clog2(MAX_HEIGHT);
    localparam int DEPTH          = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS      = $clog2(DEPTH);
    localparam int HEAT_BITS      = 24;
    localparam int COORD_BITS     = 8;
    localparam int DIM_BITS       = 7;
    localparam int DIM_EXT_BITS   = 8;
    localparam int ACTION_BITS    = 3;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;
    localparam int PROBE_BITS     = 3;
    localparam int PROBE_COUNT    = 5;

    typedef logic signed [HEAT_BITS-1:0]  heat_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [COORD_BITS:0]   pcoord_t;
    typedef logic [DIM_BITS-1:0]          dim_t;
    typedef logic [DIM_EXT_BITS-1:0]      edim_t;
    typedef logic [ADDR_BITS-1:0]         addr_t;
    typedef logic [X_BITS-1:0]            col_t;
    typedef logic [Y_BITS-1:0]            row_t;
    typedef logic [PROBE_BITS-1:0]        probe_t;

    localparam heat_t HEAT_MAX      = {1'b0, {(HEAT_BITS-1){1'b1}}};
    localparam heat_t HEAT_MIN      = {1'b1, {(HEAT_BITS-1){1'b0}}};
    localparam heat_t OUTSIDE_RESET = 24'sd255744;
    localparam dim_t  WIDTH_RESET   = 7'd64;
    localparam dim_t  HEIGHT_RESET  = 7'd64;
    localparam probe_t PROBE_HERE   = 3'd0;
    localparam probe_t PROBE_LAST   = 3'd4;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_SET     = 3'd0,
        ACT_ADD     = 3'd1,
        ACT_READ    = 3'd2,
        ACT_FILL    = 3'd3,
        ACT_HIGHEST = 3'd4,
        ACT_BELOW   = 3'd5,
        ACT_DESCEND = 3'd6,
        ACT_NONE    = 3'd7
    } action_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_WIDTH   = 2'd0,
        REG_HEIGHT  = 2'd1,
        REG_OUTSIDE = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_READ_RD,
        ST_READ_CAP,
        ST_FILL,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_DESC,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic load_item;
        logic clr_step;
        logic set_wr;
        logic item_rd;
        logic add_wr;
        logic pt_cap;
        logic fill_wr;
        logic scan_issue;
        logic desc_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic walk_last;
        logic desc_done;
    } stat_t;

    // Clamp a configured grid dimension to 1..maxv.
    function automatic edim_t eff_dim(dim_t g, edim_t maxv);
        edim_t r;
        if (g == '0)
            r = edim_t'(1);
        else if (edim_t'(g) > maxv)
            r = maxv;
        else
            r = edim_t'(g);
        return r;
    endfunction

    function automatic logic in_range(pcoord_t c, edim_t lim);
        return !c[COORD_BITS] && (c[COORD_BITS-1:0] < COORD_BITS'(lim));
    endfunction

    function automatic addr_t cell_addr(col_t x, row_t y);
        return addr_t'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

    function automatic heat_t sat_add(heat_t a, heat_t b);
        logic signed [HEAT_BITS:0] s;
        heat_t r;
        s = {a[HEAT_BITS-1], a} + {b[HEAT_BITS-1], b};
        if (s[HEAT_BITS] != s[HEAT_BITS-1])
            r = s[HEAT_BITS] ? HEAT_MIN : HEAT_MAX;
        else
            r = s[HEAT_BITS-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/hgs_if.sv =====
// Channel interfaces: item in, result out, configuration write.
interface hgs_item_if;
    import hgs_pkg::*;
    logic    valid;
    logic    ready;
    action_t action;
    coord_t  tile_x;
    coord_t  tile_y;
    heat_t   value_in;
    modport source (output valid, action, tile_x, tile_y, value_in, input ready);
    modport sink   (input valid, action, tile_x, tile_y, value_in, output ready);
endinterface

interface hgs_result_if;
    import hgs_pkg::*;
    logic   valid;
    logic   ready;
    heat_t  heat_out;
    coord_t pos_x;
    coord_t pos_y;
    logic   status;
    modport source (output valid, heat_out, pos_x, pos_y, status, input ready);
    modport sink   (input valid, heat_out, pos_x, pos_y, status, output ready);
endinterface

interface hgs_cfg_if;
    import hgs_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/hgs_ctrl.sv =====
// Controller state machine: sequences clear, point, sweep and descent work.
module hgs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  hgs_pkg::action_t item_action,
    input  logic             out_free,
    input  hgs_pkg::stat_t   stat,
    output logic             item_ready,
    output hgs_pkg::cmd_t    cmd
);
    import hgs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    unique case (item_action)
                        ACT_SET:     state_next = ST_SET;
                        ACT_ADD:     state_next = ST_ADD_RD;
                        ACT_READ:    state_next = ST_READ_RD;
                        ACT_FILL:    state_next = ST_FILL;
                        ACT_HIGHEST: state_next = ST_SCAN;
                        ACT_BELOW:   state_next = ST_SCAN;
                        ACT_DESCEND: state_next = ST_DESC;
                        ACT_NONE:    state_next = ST_RESULT;
                        default:     state_next = ST_RESULT;
                    endcase
                end
            end
            ST_SET:
            begin
                cmd.set_wr = 1'b1;
                state_next = ST_RESULT;
            end
            ST_ADD_RD:
            begin
                cmd.item_rd = 1'b1;
                state_next  = ST_ADD_WR;
            end
            ST_ADD_WR:
            begin
                cmd.add_wr = 1'b1;
                state_next = ST_RESULT;
            end
            ST_READ_RD:
            begin
                cmd.item_rd = 1'b1;
                state_next  = ST_READ_CAP;
            end
            ST_READ_CAP:
            begin
                cmd.pt_cap = 1'b1;
                state_next = ST_RESULT;
            end
            ST_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (stat.walk_last)
                    state_next = ST_RESULT;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (stat.walk_last)
                    state_next = ST_SCAN_TAIL;
            end
            ST_SCAN_TAIL:
            begin
                // last read data is compared in this cycle
                state_next = ST_RESULT;
            end
            ST_DESC:
            begin
                cmd.desc_step = 1'b1;
                if (stat.desc_done)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/hgs_datapath.sv =====
// Datapath: heat memory, address walkers, saturating add and compare logic.
module hgs_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  hgs_pkg::cmd_t    cmd,
    input  hgs_pkg::action_t in_action,
    input  hgs_pkg::coord_t  in_x,
    input  hgs_pkg::coord_t  in_y,
    input  hgs_pkg::heat_t   in_value,
    input  hgs_pkg::edim_t   eff_w,
    input  hgs_pkg::edim_t   eff_h,
    input  hgs_pkg::heat_t   outside,
    output hgs_pkg::stat_t   stat,
    output hgs_pkg::heat_t   heat,
    output hgs_pkg::coord_t  pos_x,
    output hgs_pkg::coord_t  pos_y,
    output logic             status
);
    import hgs_pkg::*;

    heat_t   mem [DEPTH];
    heat_t   mem_rdata_reg;
    logic    mem_we;
    logic    mem_re;
    addr_t   mem_waddr;
    addr_t   mem_raddr;
    heat_t   mem_wdata;

    action_t act_reg,       act_next;
    coord_t  x_reg,         x_next;
    coord_t  y_reg,         y_next;
    heat_t   value_reg,     value_next;
    heat_t   heat_reg,      heat_next;
    heat_t   here_reg,      here_next;
    coord_t  pos_x_reg,     pos_x_next;
    coord_t  pos_y_reg,     pos_y_next;
    logic    status_reg,    status_next;
    col_t    cx_reg,        cx_next;
    row_t    cy_reg,        cy_next;
    addr_t   clr_cnt_reg,   clr_cnt_next;
    logic    rd_pend_reg,   rd_pend_next;
    probe_t  probe_reg,     probe_next;
    logic    prev_valid_reg, prev_valid_next;
    probe_t  prev_probe_reg, prev_probe_next;
    logic    prev_inb_reg,  prev_inb_next;
    coord_t  prev_x_reg,    prev_x_next;
    coord_t  prev_y_reg,    prev_y_next;

    pcoord_t item_px;
    pcoord_t item_py;
    logic    item_inb;
    addr_t   item_addr;
    addr_t   walk_addr;
    logic    col_last;
    logic    row_last;
    pcoord_t probe_px;
    pcoord_t probe_py;
    logic    probe_inb;
    addr_t   probe_addr;
    logic    probe_issue;
    heat_t   probe_heat;
    logic    desc_hit;
    logic    desc_done;

    assign item_px   = pcoord_t'(x_reg);
    assign item_py   = pcoord_t'(y_reg);
    assign item_inb  = in_range(item_px, eff_w) && in_range(item_py, eff_h);
    assign item_addr = cell_addr(x_reg[X_BITS-1:0], y_reg[Y_BITS-1:0]);
    assign walk_addr = cell_addr(cx_reg, cy_reg);
    assign col_last  = edim_t'(cx_reg) == edim_t'(eff_w - edim_t'(1));
    assign row_last  = edim_t'(cy_reg) == edim_t'(eff_h - edim_t'(1));

    // Probe order: here, above, below, left, right.
    always_comb
    begin
        probe_px = item_px;
        probe_py = item_py;
        unique case (probe_reg)
            3'd1:    probe_py = item_py + pcoord_t'(1);
            3'd2:    probe_py = item_py - pcoord_t'(1);
            3'd3:    probe_px = item_px - pcoord_t'(1);
            3'd4:    probe_px = item_px + pcoord_t'(1);
            default: probe_px = item_px;
        endcase
    end

    // Stop issuing probes once the step has decided.
    assign desc_done   = prev_valid_reg && (desc_hit || prev_probe_reg == PROBE_LAST);
    assign probe_inb   = in_range(probe_px, eff_w) && in_range(probe_py, eff_h);
    assign probe_addr  = cell_addr(probe_px[X_BITS-1:0], probe_py[Y_BITS-1:0]);
    assign probe_issue = cmd.desc_step && (probe_reg <= PROBE_LAST) && !desc_done;
    assign probe_heat  = prev_inb_reg ? mem_rdata_reg : outside;
    assign desc_hit    = prev_valid_reg && (prev_probe_reg != PROBE_HERE)
                         && (probe_heat <= here_reg);

    assign stat.clr_last  = clr_cnt_reg == addr_t'(DEPTH - 1);
    assign stat.walk_last = col_last && row_last;
    assign stat.desc_done = desc_done;

    // Memory port selection
    always_comb
    begin
        mem_we    = cmd.clr_step || cmd.fill_wr
                    || ((cmd.set_wr || cmd.add_wr) && item_inb);
        mem_waddr = item_addr;
        mem_wdata = value_reg;
        if (cmd.clr_step)
        begin
            mem_waddr = clr_cnt_reg;
            mem_wdata = OUTSIDE_RESET;
        end
        else if (cmd.fill_wr)
        begin
            mem_waddr = walk_addr;
        end
        else if (cmd.add_wr)
        begin
            mem_wdata = sat_add(mem_rdata_reg, value_reg);
        end
        mem_re    = cmd.item_rd || cmd.scan_issue || probe_issue;
        mem_raddr = item_addr;
        if (cmd.scan_issue)
            mem_raddr = walk_addr;
        else if (probe_issue)
            mem_raddr = probe_addr;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        act_next        = act_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        value_next      = value_reg;
        heat_next       = heat_reg;
        here_next       = here_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        status_next     = status_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        clr_cnt_next    = clr_cnt_reg;
        probe_next      = probe_reg;
        rd_pend_next    = cmd.scan_issue;
        prev_valid_next = probe_issue;
        prev_probe_next = probe_reg;
        prev_inb_next   = probe_inb;
        prev_x_next     = probe_px[COORD_BITS-1:0];
        prev_y_next     = probe_py[COORD_BITS-1:0];

        if (cmd.clr_step)
            clr_cnt_next = clr_cnt_reg + addr_t'(1);

        if (cmd.load_item)
        begin
            act_next    = in_action;
            x_next      = in_x;
            y_next      = in_y;
            value_next  = in_value;
            heat_next   = '0;
            pos_x_next  = in_x;
            pos_y_next  = in_y;
            status_next = 1'b0;
            cx_next     = '0;
            cy_next     = '0;
            probe_next  = PROBE_HERE;
        end

        if (cmd.set_wr || cmd.add_wr)
            status_next = !item_inb;

        if (cmd.pt_cap)
            heat_next = item_inb ? mem_rdata_reg : outside;

        // Advance the row-major walk over the tiles in use
        if (cmd.fill_wr || cmd.scan_issue)
        begin
            if (col_last)
            begin
                cx_next = '0;
                cy_next = cy_reg + row_t'(1);
            end
            else
            begin
                cx_next = cx_reg + col_t'(1);
            end
        end

        if (rd_pend_reg && (mem_rdata_reg > heat_reg)
            && (act_reg != ACT_BELOW || mem_rdata_reg < value_reg))
            heat_next = mem_rdata_reg;

        if (probe_issue)
            probe_next = probe_reg + probe_t'(1);

        if (prev_valid_reg && prev_probe_reg == PROBE_HERE)
            here_next = probe_heat;

        if (desc_hit)
        begin
            pos_x_next = prev_x_reg;
            pos_y_next = prev_y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg    <= '0;
            rd_pend_reg    <= 1'b0;
            probe_reg      <= PROBE_HERE;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            clr_cnt_reg    <= clr_cnt_next;
            rd_pend_reg    <= rd_pend_next;
            probe_reg      <= probe_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        value_reg      <= value_next;
        heat_reg       <= heat_next;
        here_reg       <= here_next;
        pos_x_reg      <= pos_x_next;
        pos_y_reg      <= pos_y_next;
        status_reg     <= status_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        prev_probe_reg <= prev_probe_next;
        prev_inb_reg   <= prev_inb_next;
        prev_x_reg     <= prev_x_next;
        prev_y_reg     <= prev_y_next;
    end

    assign heat   = heat_reg;
    assign pos_x  = pos_x_reg;
    assign pos_y  = pos_y_reg;
    assign status = status_reg;

endmodule

// ===== hdl/heat_grid_store.sv =====
// Work per item: descend makes one memory read per probe, and a finished result
//   waits until the result slot is free.
// Throughput: one item at a time; the heat memory, with one read and one write port, sets the pace, and the
//   next item is taken while the previous result waits in the output register.
// Reset: a clearing pass writes 999.0 into every tile; no item is
//   taken during it, while configuration writes are taken at any time.
module heat_grid_store (
    input  logic        clk,
    input  logic        rst_n,
    hgs_item_if.sink    item,
    hgs_result_if.source result,
    hgs_cfg_if.sink     cfg
);
    import hgs_pkg::*;

    // Configuration registers
    dim_t   width_reg,   width_next;
    dim_t   height_reg,  height_next;
    heat_t  outside_reg, outside_next;
    edim_t  eff_w;
    edim_t  eff_h;

    // Result register parting the work from the downstream side
    logic   out_valid_reg, out_valid_next;
    heat_t  out_heat_reg;
    coord_t out_x_reg;
    coord_t out_y_reg;
    logic   out_status_reg;
    logic   out_free;

    // Controller to datapath
    cmd_t   cmd;
    stat_t  stat;
    logic   item_ready;

    heat_t  dp_heat;
    coord_t dp_x;
    coord_t dp_y;
    logic   dp_status;

    assign cfg.ready = 1'b1;

    // Accept a configuration transfer; unknown indexes are dropped.
    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        outside_next = outside_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_WIDTH:   width_next   = cfg.data[DIM_BITS-1:0];
                REG_HEIGHT:  height_next  = cfg.data[DIM_BITS-1:0];
                REG_OUTSIDE: outside_next = cfg.data[HEAT_BITS-1:0];
                default:     width_next   = width_reg;
            endcase
        end
    end

    // Grid size as used: zero counts as one, oversize clamps to the store.
    assign eff_w = eff_dim(width_reg,  edim_t'(MAX_WIDTH));
    assign eff_h = eff_dim(height_reg, edim_t'(MAX_HEIGHT));

    // The result slot is free when empty or when its transfer completes now.
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
            outside_reg   <= OUTSIDE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            outside_reg   <= outside_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload until the next load.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_heat_reg   <= dp_heat;
            out_x_reg      <= dp_x;
            out_y_reg      <= dp_y;
            out_status_reg <= dp_status;
        end
    end

    assign item.ready      = item_ready;
    assign result.valid    = out_valid_reg;
    assign result.heat_out = out_heat_reg;
    assign result.pos_x    = out_x_reg;
    assign result.pos_y    = out_y_reg;
    assign result.status   = out_status_reg;

    hgs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item.valid),
        .item_action (item.action),
        .out_free    (out_free),
        .stat        (stat),
        .item_ready  (item_ready),
        .cmd         (cmd)
    );

    hgs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_action (item.action),
        .in_x      (item.tile_x),
        .in_y      (item.tile_y),
        .in_value  (item.value_in),
        .eff_w     (eff_w),
        .eff_h     (eff_h),
        .outside   (outside_reg),
        .stat      (stat),
        .heat      (dp_heat),
        .pos_x     (dp_x),
        .pos_y     (dp_y),
        .status    (dp_status)
    );

`ifndef SYNTHESIS
    // One item at a time: never two item transfers on consecutive edges.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> !item.ready)
        else $error("item taken while previous item still in work");

    // A new result is only loaded into a free result slot.
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || result.ready))
        else $error("result overwritten before transfer");

    // No item is taken during the clearing pass.
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !item.ready)
        else $error("item ready during clearing pass");
`endif

endmodule
